@@ rtl/core/cst_pkg.sv @@
`timescale 1ns / 1ps

package cst_pkg;

    localparam int ENTRIES     = 8;
    localparam int HANDLE_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_TAKE   = 2'd1,
        OP_GIVE   = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_UNAVAIL = 2'd1,
        STS_ERROR   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CREATE,
        S_SCAN,
        S_UPDATE
    } state_t;

    typedef struct packed {
        op_t         mode;
        logic [15:0] handle;
        logic [15:0] init_count;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] new_handle;
    } rsp_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [COUNT_BITS-1:0]  count;
        logic [COUNT_BITS-1:0]  ceiling;
    } entry_t;

endpackage

@@ rtl/core/counting_semaphore_table_top.sv @@
`timescale 1ns / 1ps

// Counting semaphore table.
// Command channel: drive req and pulse start while busy is low; the beat is
// taken at that edge and busy rises on the next cycle until the op is done.
// Result channel: done is high for exactly one cycle with rsp holding the
// status and, for a successful create, the new handle. The receiver cannot
// stall; the result is gone after that cycle.
// Create picks the lowest free slot from per-slot valid flops and passes
// through S_CREATE, which registers done. Take, give and delete walk the
// slot memory one entry a cycle through its registered read port until the
// handle matches, then act on the slot in S_UPDATE; if no entry matches,
// done comes with an error status once the last entry has been checked.
// A new command may be issued in the same cycle that done is high.
// Reset empties the table at once (all valid flops clear) and sets the next
// handle to 1; no clearing pass is needed.
module counting_semaphore_table_top (
    clk,
    rst_n,
    start,
    busy,
    req,
    done,
    rsp
);
    import cst_pkg::*;

    input  logic          clk;
    input  logic          rst_n;
    input  logic          start;
    output logic          busy;
    input  cst_pkg::req_t req;
    output logic          done;
    output cst_pkg::rsp_t rsp;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t state_reg, state_next;

    op_t                    op_reg, op_next;
    logic [HANDLE_BITS-1:0] hdl_reg, hdl_next;
    logic [COUNT_BITS-1:0]  init_reg, init_next;
    logic [HANDLE_BITS-1:0] next_handle_reg, next_handle_next;
    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [IDX_W-1:0]       rd_addr_reg, rd_addr_next;
    logic [IDX_W-1:0]       chk_addr_reg, chk_addr_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]       hit_reg, hit_next;
    entry_t                 entry_reg, entry_next;
    logic                   done_reg, done_next;
    rsp_t                   rsp_reg, rsp_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    entry_t                 ram_wdata;
    entry_t                 ram_rdata;

    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;
    logic                   match;
    logic [HANDLE_BITS-1:0] handle_inc;

    cst_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // read data belongs to chk_addr_reg; a free slot never matches
    assign match = chk_vld_reg && valid_reg[chk_addr_reg] && (ram_rdata.handle == hdl_reg);

    assign handle_inc = next_handle_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (req.mode == OP_CREATE) ? S_CREATE : S_SCAN;
                end
            end
            S_CREATE:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (match)
                begin
                    state_next = S_UPDATE;
                end
                else if (chk_vld_reg && chk_addr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next          = op_reg;
        hdl_next         = hdl_reg;
        init_next        = init_reg;
        next_handle_next = next_handle_reg;
        valid_next       = valid_reg;
        rd_addr_next     = rd_addr_reg;
        chk_addr_next    = chk_addr_reg;
        chk_vld_next     = chk_vld_reg;
        hit_next         = hit_reg;
        entry_next       = entry_reg;
        done_next        = 1'b0;
        rsp_next         = rsp_reg;
        ram_we           = 1'b0;
        ram_waddr        = hit_reg;
        ram_wdata        = entry_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = req.mode;
                    hdl_next     = HANDLE_BITS'(req.handle);
                    init_next    = COUNT_BITS'(req.init_count);
                    rd_addr_next = '0;
                    chk_vld_next = 1'b0;
                end
            end
            S_CREATE:
            begin
                done_next = 1'b1;
                if (free_found)
                begin
                    ram_we                = 1'b1;
                    ram_waddr             = free_idx;
                    ram_wdata.handle      = next_handle_reg;
                    ram_wdata.count       = init_reg;
                    ram_wdata.ceiling     = init_reg;
                    valid_next[free_idx]  = 1'b1;
                    rsp_next.status       = STS_OK;
                    rsp_next.new_handle   = 16'(next_handle_reg);
                    // counter wraps past zero to one
                    next_handle_next      = (handle_inc == '0) ? HANDLE_BITS'(1) : handle_inc;
                end
                else
                begin
                    rsp_next.status     = STS_ERROR;
                    rsp_next.new_handle = '0;
                end
            end
            S_SCAN:
            begin
                chk_addr_next = rd_addr_reg;
                chk_vld_next  = 1'b1;
                rd_addr_next  = rd_addr_reg + 1'b1;
                if (match)
                begin
                    hit_next   = chk_addr_reg;
                    entry_next = ram_rdata;
                end
                else if (chk_vld_reg && chk_addr_reg == LAST_IDX)
                begin
                    done_next           = 1'b1;
                    rsp_next.status     = STS_ERROR;
                    rsp_next.new_handle = '0;
                end
            end
            S_UPDATE:
            begin
                done_next           = 1'b1;
                rsp_next.new_handle = '0;
                case (op_reg)
                    OP_TAKE:
                    begin
                        if (entry_reg.count != '0)
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.count = entry_reg.count - 1'b1;
                            rsp_next.status = STS_OK;
                        end
                        else
                        begin
                            rsp_next.status = STS_UNAVAIL;
                        end
                    end
                    OP_GIVE:
                    begin
                        if (entry_reg.count < entry_reg.ceiling)
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.count = entry_reg.count + 1'b1;
                            rsp_next.status = STS_OK;
                        end
                        else
                        begin
                            rsp_next.status = STS_ERROR;
                        end
                    end
                    OP_DELETE:
                    begin
                        // clearing the valid flop frees the slot
                        valid_next[hit_reg] = 1'b0;
                        rsp_next.status     = STS_OK;
                    end
                    default:
                    begin
                        rsp_next.status = STS_ERROR;
                    end
                endcase
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            next_handle_reg <= HANDLE_BITS'(1);
            valid_reg       <= '0;
            chk_vld_reg     <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            next_handle_reg <= next_handle_next;
            valid_reg       <= valid_next;
            chk_vld_reg     <= chk_vld_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        hdl_reg      <= hdl_next;
        init_reg     <= init_next;
        rd_addr_reg  <= rd_addr_next;
        chk_addr_reg <= chk_addr_next;
        hit_reg      <= hit_next;
        entry_reg    <= entry_next;
        rsp_reg      <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

@@ rtl/core/cst_ram.sv @@
`timescale 1ns / 1ps

module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    clk,
    we,
    waddr,
    wdata,
    raddr,
    rdata
);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic              clk;
    input  logic              we;
    input  logic [ADDR_W-1:0] waddr;
    input  logic [WIDTH-1:0]  wdata;
    input  logic [ADDR_W-1:0] raddr;
    output logic [WIDTH-1:0]  rdata;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
